@@ src/dpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpa_pkg
// shared types and constants of the delta patch applier
// ----------------------------------------------------------------------------
package dpa_pkg;

    localparam int LEN_WIDTH = 32;

    localparam logic [63:0] MAGIC_RESET = 64'h4444_454C_5441_3430;

    localparam logic [4:0] CNT_MAGIC_END = 5'd8;
    localparam logic [4:0] CNT_SIZE_END  = 5'd16;
    localparam logic [4:0] CNT_DIFF_END  = 5'd8;
    localparam logic [4:0] CNT_EXTRA_END = 5'd16;
    localparam logic [4:0] CNT_SEEK_END  = 5'd24;

    localparam logic [7:0] CFG_OLD_BASE = 8'd0;
    localparam logic [7:0] CFG_MAGIC    = 8'd1;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ENTRY,
        PH_DIFF,
        PH_COPY,
        PH_STOP
    } phase_t;

    typedef enum logic [2:0] {
        ST_BUSY  = 3'd0,
        ST_OK    = 3'd1,
        ST_MAGIC = 3'd2,
        ST_SIZE  = 3'd3,
        ST_LONG  = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] old_byte;
        logic [7:0] patch_byte;
    } item_t;

    typedef struct packed {
        logic valid;
    } queue_ctl_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] old_address;
        logic [7:0]  new_byte;
    } result_t;

endpackage

@@ src/dpa_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpa_front
// accepts patch requests into a two-entry queue ahead of the core
// ----------------------------------------------------------------------------
module dpa_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  dpa_pkg::item_t  in_item,
    output dpa_pkg::item_t  head_item,
    input  logic            head_pop,
    output dpa_pkg::queue_ctl_t q_ctl
);
    import dpa_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready   = (count_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign pop        = head_pop && (count_reg != 2'd0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign q_ctl.valid = (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ src/dpa_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpa_core
// patch parser and byte rebuilder with an output register
// ----------------------------------------------------------------------------
module dpa_core (
    input  logic                clk,
    input  logic                rst_n,
    input  dpa_pkg::queue_ctl_t q_ctl,
    input  dpa_pkg::item_t      head_item,
    output logic                head_pop,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dpa_pkg::result_t    out_result,
    output logic                out_new_valid
);
    import dpa_pkg::*;

    phase_t               phase_reg, phase_next;
    status_t              status_reg, status_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [63:0]          field_reg, field_next;
    logic [LEN_WIDTH-1:0] new_size_reg, new_size_next;
    logic [LEN_WIDTH-1:0] diff_len_reg, diff_len_next;
    logic                 diff_over_reg, diff_over_next;
    logic [LEN_WIDTH-1:0] extra_len_reg, extra_len_next;
    logic                 extra_over_reg, extra_over_next;
    logic [31:0]          seek_reg, seek_next;
    logic [LEN_WIDTH-1:0] remain_reg, remain_next;
    logic [LEN_WIDTH-1:0] written_reg, written_next;
    logic [31:0]          offset_reg, offset_next;
    logic [31:0]          base_reg;
    logic [63:0]          magic_reg;
    logic                 out_valid_reg;
    result_t              out_result_reg;
    logic                 out_nv_reg;

    logic [63:0]          shifted;
    logic [4:0]           cnt_inc;
    logic [LEN_WIDTH-1:0] remain_dec;
    logic [LEN_WIDTH-1:0] written_sum;
    logic [31:0]          seek_use;
    logic [31:0]          offset_step;
    logic                 do_finish;
    logic                 advance;
    logic [7:0]           nb;
    logic                 nv;

    assign advance    = q_ctl.valid && (!out_valid_reg || out_ready);
    assign head_pop   = advance;
    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;
    assign out_new_valid = out_nv_reg;

    assign shifted     = {field_reg[55:0], head_item.patch_byte};
    assign cnt_inc     = cnt_reg + 5'd1;
    assign remain_dec  = remain_reg - {{(LEN_WIDTH-1){1'b0}}, 1'b1};
    assign written_sum = written_reg + diff_len_reg + extra_len_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        status_next     = status_reg;
        cnt_next        = cnt_reg;
        field_next      = field_reg;
        new_size_next   = new_size_reg;
        diff_len_next   = diff_len_reg;
        diff_over_next  = diff_over_reg;
        extra_len_next  = extra_len_reg;
        extra_over_next = extra_over_reg;
        seek_next       = seek_reg;
        remain_next     = remain_reg;
        written_next    = written_reg;
        offset_step     = offset_reg;
        seek_use        = seek_reg;
        do_finish       = 1'b0;
        nb              = 8'd0;
        nv              = 1'b0;

        if (status_reg == ST_BUSY)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    field_next = shifted;
                    cnt_next   = cnt_inc;
                    if (cnt_inc == CNT_MAGIC_END)
                    begin
                        if (shifted != magic_reg)
                        begin
                            status_next = ST_MAGIC;
                            phase_next  = PH_STOP;
                        end
                        field_next = 64'd0;
                    end
                    else if (cnt_inc >= CNT_SIZE_END)
                    begin
                        if ((shifted >> LEN_WIDTH) != 64'd0)
                        begin
                            status_next = ST_LONG;
                            phase_next  = PH_STOP;
                        end
                        else
                        begin
                            new_size_next = shifted[LEN_WIDTH-1:0];
                            phase_next    = PH_ENTRY;
                            cnt_next      = 5'd0;
                            field_next    = 64'd0;
                        end
                    end
                end
                PH_ENTRY:
                begin
                    field_next = shifted;
                    cnt_next   = cnt_inc;
                    if (cnt_inc == CNT_DIFF_END)
                    begin
                        diff_len_next  = shifted[LEN_WIDTH-1:0];
                        diff_over_next = ((shifted >> LEN_WIDTH) != 64'd0);
                        field_next     = 64'd0;
                    end
                    else if (cnt_inc == CNT_EXTRA_END)
                    begin
                        extra_len_next  = shifted[LEN_WIDTH-1:0];
                        extra_over_next = ((shifted >> LEN_WIDTH) != 64'd0);
                        field_next      = 64'd0;
                    end
                    else if (cnt_inc >= CNT_SEEK_END)
                    begin
                        if ((diff_len_reg == '0) && !diff_over_reg
                            && (extra_len_reg == '0) && !extra_over_reg
                            && (shifted == 64'd0))
                        begin
                            status_next = (written_reg == new_size_reg) ? ST_OK : ST_SIZE;
                            phase_next  = PH_STOP;
                        end
                        else if (diff_over_reg || extra_over_reg)
                        begin
                            status_next = ST_LONG;
                            phase_next  = PH_STOP;
                        end
                        else
                        begin
                            seek_next  = shifted[31:0];
                            seek_use   = shifted[31:0];
                            cnt_next   = 5'd0;
                            field_next = 64'd0;
                            if (diff_len_reg != '0)
                            begin
                                phase_next  = PH_DIFF;
                                remain_next = diff_len_reg;
                            end
                            else if (extra_len_reg != '0)
                            begin
                                phase_next  = PH_COPY;
                                remain_next = extra_len_reg;
                            end
                            else
                            begin
                                do_finish = 1'b1;
                            end
                        end
                    end
                end
                PH_DIFF:
                begin
                    nb          = head_item.old_byte + head_item.patch_byte;
                    nv          = 1'b1;
                    offset_step = offset_reg + 32'd1;
                    remain_next = remain_dec;
                    if (remain_dec == '0)
                    begin
                        if (extra_len_reg != '0)
                        begin
                            phase_next  = PH_COPY;
                            remain_next = extra_len_reg;
                        end
                        else
                        begin
                            do_finish = 1'b1;
                        end
                    end
                end
                PH_COPY:
                begin
                    nb          = head_item.patch_byte;
                    nv          = 1'b1;
                    remain_next = remain_dec;
                    if (remain_dec == '0)
                    begin
                        do_finish = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        offset_next = offset_step;
        if (do_finish)
        begin
            offset_next  = offset_step + seek_use;
            written_next = written_sum;
            phase_next   = PH_ENTRY;
            cnt_next     = 5'd0;
            field_next   = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            status_reg     <= ST_BUSY;
            cnt_reg        <= 5'd0;
            field_reg      <= 64'd0;
            new_size_reg   <= '0;
            diff_len_reg   <= '0;
            diff_over_reg  <= 1'b0;
            extra_len_reg  <= '0;
            extra_over_reg <= 1'b0;
            seek_reg       <= 32'd0;
            remain_reg     <= '0;
            written_reg    <= '0;
            offset_reg     <= 32'd0;
            base_reg       <= 32'd0;
            magic_reg      <= MAGIC_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg      <= phase_next;
                status_reg     <= status_next;
                cnt_reg        <= cnt_next;
                field_reg      <= field_next;
                new_size_reg   <= new_size_next;
                diff_len_reg   <= diff_len_next;
                diff_over_reg  <= diff_over_next;
                extra_len_reg  <= extra_len_next;
                extra_over_reg <= extra_over_next;
                seek_reg       <= seek_next;
                remain_reg     <= remain_next;
                written_reg    <= written_next;
                offset_reg     <= offset_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_OLD_BASE: base_reg  <= cfg_data[31:0];
                    CFG_MAGIC:    magic_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg.new_byte    <= nb;
            out_result_reg.old_address <= base_reg + offset_next;
            out_result_reg.status      <= status_next;
            out_nv_reg                 <= nv;
        end
    end

endmodule

@@ src/delta_patch_applier_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_patch_applier_top
// streaming patch applier: header and entry parsing, diff add and copy
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata = patch_byte, old_byte
//   m_*      out  m_tvalid/m_tready  m_tdata = new_byte, old_address, status
//                                    m_tuser = new_valid
//   cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// one request a cycle sustained while the output accepts; each result is
// registered at the edge that takes its request from the two-entry input queue
// the byte update is a single step of the core's parse state machine
// rst_n clears parse state, status, queue and output valid; no clearing pass
// a stalled output keeps the core idle while the queue absorbs two requests
// cfg_ready is always high
// ----------------------------------------------------------------------------
module delta_patch_applier_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // patch_byte, old_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // new_byte, old_address, status, zero fill
    output logic [0:0]  m_tuser,   // new_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import dpa_pkg::*;

    item_t      in_item;
    item_t      head_item;
    logic       head_pop;
    queue_ctl_t q_ctl;
    result_t    result;
    logic       new_valid;

    assign in_item.patch_byte = s_tdata[7:0];
    assign in_item.old_byte   = s_tdata[15:8];
    assign cfg_ready          = 1'b1;

    dpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .head_item (head_item),
        .head_pop  (head_pop),
        .q_ctl     (q_ctl)
    );

    dpa_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_ctl         (q_ctl),
        .head_item     (head_item),
        .head_pop      (head_pop),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_result    (result),
        .out_new_valid (new_valid)
    );

    assign m_tdata = {5'd0, result};
    assign m_tuser = new_valid;

endmodule

@@ src/dpa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpa_checker
// port-level checks of the delta patch applier, bound to the top level
// ----------------------------------------------------------------------------
module dpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser
);
    import dpa_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // an emitted byte comes only while in progress
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[42:40] == ST_BUSY)
        else $error("byte emitted after end");

    // no byte means zero data byte
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
        else $error("non-zero byte without new_valid");

    // final status is sticky across back-to-back results
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tdata[42:40] != ST_BUSY
        |=> !m_tvalid || m_tdata[42:40] == $past(m_tdata[42:40]))
        else $error("status left its final value");

endmodule

bind delta_patch_applier_top dpa_checker u_dpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ bench/rebuild_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebuild_checker
// watches the patch, output and register channels of the patch applier,
// works out the rebuilt byte, old address and status for every accepted
// request and compares each output result with the oldest one still owed
// ----------------------------------------------------------------------------
module rebuild_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          mismatches,
    output int          pending
);
    import dpa_pkg::*;

    localparam logic [63:0] LEN_MASK =
        (LEN_WIDTH >= 64) ? '1 : ((64'd1 << LEN_WIDTH) - 64'd1);

    typedef struct packed {
        logic [7:0]  new_byte;
        logic        new_valid;
        logic [31:0] old_address;
        logic [2:0]  status;
    } rebuilt_t;

    rebuilt_t    rebuilt_q[$];

    logic [31:0] image_base;
    logic [63:0] magic;
    phase_t      ph;
    status_t     stat;
    logic [4:0]  field_bytes;
    logic [63:0] field_acc;
    logic [63:0] new_size;
    logic [63:0] diff_len;
    logic [63:0] extra_len;
    logic [63:0] run_left;
    logic [63:0] written;
    logic [31:0] seek;
    logic [31:0] offset;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatches = mismatches + 1;
    endtask

    // seek and written count update at the end of an entry
    task automatic close_entry();
        offset = offset + seek;
        written = (written + diff_len + extra_len) & LEN_MASK;
        ph = PH_ENTRY;
        field_bytes = 5'd0;
        field_acc = 64'd0;
    endtask

    task automatic open_copy();
        if (extra_len != 64'd0)
        begin
            ph = PH_COPY;
            run_left = extra_len;
        end
        else
            close_entry();
    endtask

    task automatic apply_patch_byte(input logic [7:0] pb, input logic [7:0] ob,
                                    output rebuilt_t r);
        r.new_byte = 8'd0;
        r.new_valid = 1'b0;
        if (stat == ST_BUSY)
        begin
            case (ph)
                PH_HEADER:
                begin
                    field_acc = {field_acc[55:0], pb};
                    field_bytes = field_bytes + 5'd1;
                    if (field_bytes == CNT_MAGIC_END)
                    begin
                        if (field_acc != magic)
                        begin
                            stat = ST_MAGIC;
                            ph = PH_STOP;
                        end
                        field_acc = 64'd0;
                    end
                    else if (field_bytes >= CNT_SIZE_END)
                    begin
                        if ((field_acc & ~LEN_MASK) != 64'd0)
                        begin
                            stat = ST_LONG;
                            ph = PH_STOP;
                        end
                        else
                        begin
                            new_size = field_acc;
                            ph = PH_ENTRY;
                            field_bytes = 5'd0;
                            field_acc = 64'd0;
                        end
                    end
                end
                PH_ENTRY:
                begin
                    field_acc = {field_acc[55:0], pb};
                    field_bytes = field_bytes + 5'd1;
                    if (field_bytes == CNT_DIFF_END)
                    begin
                        diff_len = field_acc;
                        field_acc = 64'd0;
                    end
                    else if (field_bytes == CNT_EXTRA_END)
                    begin
                        extra_len = field_acc;
                        field_acc = 64'd0;
                    end
                    else if (field_bytes >= CNT_SEEK_END)
                    begin
                        // all-zero entry ends the patch before any length check
                        if (diff_len == 64'd0 && extra_len == 64'd0 && field_acc == 64'd0)
                        begin
                            stat = (written == new_size) ? ST_OK : ST_SIZE;
                            ph = PH_STOP;
                        end
                        else if (((diff_len | extra_len) & ~LEN_MASK) != 64'd0)
                        begin
                            stat = ST_LONG;
                            ph = PH_STOP;
                        end
                        else
                        begin
                            seek = field_acc[31:0];
                            field_bytes = 5'd0;
                            field_acc = 64'd0;
                            if (diff_len != 64'd0)
                            begin
                                ph = PH_DIFF;
                                run_left = diff_len;
                            end
                            else
                                open_copy();
                        end
                    end
                end
                PH_DIFF:
                begin
                    r.new_byte = ob + pb;
                    r.new_valid = 1'b1;
                    offset = offset + 32'd1;
                    run_left = run_left - 64'd1;
                    if (run_left == 64'd0)
                        open_copy();
                end
                PH_COPY:
                begin
                    r.new_byte = pb;
                    r.new_valid = 1'b1;
                    run_left = run_left - 64'd1;
                    if (run_left == 64'd0)
                        close_entry();
                end
                default:
                begin
                end
            endcase
        end
        r.old_address = image_base + offset;
        r.status = stat;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        rebuilt_t want;
        item_t    req;
        if (!rst_n)
        begin
            rebuilt_q.delete();
            image_base = 32'd0;
            magic = MAGIC_RESET;
            ph = PH_HEADER;
            stat = ST_BUSY;
            field_bytes = 5'd0;
            field_acc = 64'd0;
            new_size = 64'd0;
            diff_len = 64'd0;
            extra_len = 64'd0;
            run_left = 64'd0;
            written = 64'd0;
            seek = 32'd0;
            offset = 32'd0;
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_OLD_BASE)
                    image_base = cfg_data[31:0];
                else if (cfg_index == CFG_MAGIC)
                    magic = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                if (rebuilt_q.size() == 0)
                    report_mismatch("result with nothing expected", 64'(m_tdata), 64'd0);
                else
                begin
                    want = rebuilt_q.pop_front();
                    if (m_tdata[7:0] != want.new_byte)
                        report_mismatch("new_byte", 64'(m_tdata[7:0]), 64'(want.new_byte));
                    if (m_tuser[0] != want.new_valid)
                        report_mismatch("new_valid", 64'(m_tuser[0]), 64'(want.new_valid));
                    if (m_tdata[39:8] != want.old_address)
                        report_mismatch("old_address", 64'(m_tdata[39:8]),
                                        64'(want.old_address));
                    if (m_tdata[42:40] != want.status)
                        report_mismatch("status", 64'(m_tdata[42:40]), 64'(want.status));
                end
            end
            if (s_tvalid && s_tready)
            begin
                req = item_t'(s_tdata);
                apply_patch_byte(req.patch_byte, req.old_byte, want);
                rebuilt_q.push_back(want);
            end
            pending <= rebuilt_q.size();
        end
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// streams one patch into the applier: header, a handful of hand-made entries,
// many random well-formed entries and a random ending (clean end, size mismatch
// or oversized length) with trailing bytes, or bad magic or oversized size and
// random bytes; register writes fall between phases, both sides idle at random
// ----------------------------------------------------------------------------
module tb;
    import dpa_pkg::*;

    localparam int ITEMS            = 900;
    localparam int DIRECTED_ENTRIES = 5;
    localparam int HOLD_CYCLES      = 60;
    localparam int LIMIT_CYCLES     = 100000;

    typedef enum int {
        END_CLEAN,
        END_SIZE,
        END_MAGIC,
        END_LONG_SIZE,
        END_LONG_DIFF,
        END_LONG_EXTRA
    } ending_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [63:0] cfg_data;

    logic [15:0] stream_q[$];
    logic [63:0] diff_plan[$];
    logic [63:0] extra_plan[$];
    logic [63:0] seek_plan[$];
    logic [63:0] planned_total;
    int          planned_items;
    bit          calm;
    bit          hold_go;
    int          mismatches;
    int          pending;
    int          cycles;

    always #5 clk = ~clk;

    delta_patch_applier_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rebuild_checker rebuild_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic void put_req(input logic [7:0] pb, input logic [7:0] ob);
        stream_q.push_back({ob, pb});
    endfunction

    // big-endian, most significant byte first
    function automatic void put_field(input logic [63:0] value);
        for (int k = 7; k >= 0; k--)
            put_req(value[k * 8 +: 8], 8'($urandom_range(255)));
    endfunction

    function automatic void put_payload(input int count, input bit extremes);
        for (int k = 0; k < count; k++)
        begin
            if (extremes)
                put_req(k[0] ? 8'hFF : 8'h00, k[1] ? 8'hFF : 8'h00);
            else
                put_req(8'($urandom_range(255)), 8'($urandom_range(255)));
        end
    endfunction

    function automatic void plan_entry(input logic [63:0] d, input logic [63:0] e,
                                       input logic [63:0] s);
        diff_plan.push_back(d);
        extra_plan.push_back(e);
        seek_plan.push_back(s);
        planned_total = planned_total + d + e;
        planned_items = planned_items + 24 + int'(d + e);
    endfunction

    function automatic logic [63:0] pick_length();
        logic [63:0] n;
        n = ($urandom_range(3) == 0) ? 64'd0 : 64'($urandom_range(1, 16));
        if ($urandom_range(19) == 0)
            n = 64'($urandom_range(40, 80));
        return n;
    endfunction

    function automatic logic [63:0] pick_seek();
        logic [31:0] near;
        near = 32'($urandom_range(64)) - 32'd32;
        case ($urandom_range(3))
            0: return {{32{near[31]}}, near};
            1: return {32'($urandom), 32'($urandom)};
            2: return 64'd0;
            default: return {32'($urandom), near};
        endcase
    endfunction

    task automatic write_register(input logic [7:0] reg_index, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        ending_t     ending;
        logic [63:0] magic;
        logic [63:0] size_field;
        logic [63:0] huge;
        logic [63:0] d_len;
        logic [63:0] e_len;
        logic [63:0] s_val;
        int          pick;
        int          directed_end;
        int          hold_at;
        int          calm_from;
        int          gap_odds;
        int          n_break;
        int          brk[3];

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 16'd0;
        cfg_valid = 1'b0;
        cfg_index = 8'd0;
        cfg_data = 64'd0;

        pick = $urandom_range(99);
        if (pick < 45)
            ending = END_CLEAN;
        else if (pick < 65)
            ending = END_SIZE;
        else if (pick < 80)
            ending = END_LONG_DIFF;
        else if (pick < 90)
            ending = END_LONG_EXTRA;
        else if (pick < 95)
            ending = END_MAGIC;
        else
            ending = END_LONG_SIZE;

        case ($urandom_range(3))
            0: magic = MAGIC_RESET;
            1: magic = 64'd0;
            2: magic = '1;
            default: magic = {32'($urandom), 32'($urandom)};
        endcase

        // hand-made entries: negative seek, seek with junk high half,
        // zero diff, zero extra, empty runs with a non-zero seek
        planned_total = 64'd0;
        planned_items = 16;
        plan_entry(64'd4, 64'd2, 64'hFFFF_FFFF_FFFF_FFF8);
        plan_entry(64'd0, 64'd1, 64'h7FFF_FFFF_0000_0003);
        plan_entry(64'd1, 64'd0, 64'd0);
        plan_entry(64'd0, 64'd0, 64'h8000_0000_0000_0000);
        plan_entry(64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        while (planned_items < ITEMS)
        begin
            d_len = pick_length();
            e_len = pick_length();
            s_val = pick_seek();
            // keep an all-zero entry for the end
            if (d_len == 64'd0 && e_len == 64'd0 && s_val == 64'd0)
                s_val = 64'd1;
            plan_entry(d_len, e_len, s_val);
        end

        put_field((ending == END_MAGIC) ? magic ^ (64'd1 << $urandom_range(63)) : magic);
        case (ending)
            END_SIZE:
                size_field = $urandom_range(1) ? planned_total + 64'($urandom_range(1, 9))
                                               : planned_total - 64'd1;
            END_LONG_SIZE:
                size_field = {($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF), 32'($urandom)};
            default:
                size_field = planned_total;
        endcase
        put_field(size_field);

        directed_end = 12;
        if (ending == END_MAGIC || ending == END_LONG_SIZE)
            put_payload(planned_items, 1'b0);
        else
        begin
            for (int k = 0; k < diff_plan.size(); k++)
            begin
                put_field(diff_plan[k]);
                put_field(extra_plan[k]);
                put_field(seek_plan[k]);
                put_payload(int'(diff_plan[k] + extra_plan[k]), k == 0);
                if (k == DIRECTED_ENTRIES - 1)
                    directed_end = stream_q.size();
            end
            huge = {32'd1 << $urandom_range(31), 32'($urandom)};
            case (ending)
                END_LONG_DIFF:
                begin
                    put_field(huge);
                    put_field(64'd3);
                    put_field(pick_seek());
                end
                END_LONG_EXTRA:
                begin
                    put_field(64'd3);
                    put_field(huge);
                    put_field(pick_seek());
                end
                default:
                    repeat (3) put_field(64'd0);
            endcase
            // trailing bytes after the end must be ignored
            put_payload(20, 1'b0);
        end

        brk[0] = directed_end;
        brk[1] = directed_end + (stream_q.size() - directed_end) / 3;
        brk[2] = directed_end + 2 * (stream_q.size() - directed_end) / 3;
        hold_at = directed_end + 20;
        calm_from = stream_q.size() - ((stream_q.size() > 300) ? 100 : 10);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_register(CFG_OLD_BASE, $urandom_range(1) ? 64'd0 : 64'($urandom));
        write_register(CFG_MAGIC, magic);

        n_break = 0;
        gap_odds = 0;
        for (int i = 0; i < stream_q.size(); i++)
        begin
            if (n_break < 3 && i == brk[n_break])
            begin
                s_tvalid <= 1'b0;
                do @(posedge clk); while (pending != 0);
                case (n_break)
                    0:
                        write_register(CFG_OLD_BASE, 64'hFFFF_FFFF);
                    1:
                    begin
                        write_register(CFG_OLD_BASE, 64'($urandom));
                        write_register(CFG_MAGIC, 64'd0);
                    end
                    default:
                    begin
                        write_register(CFG_OLD_BASE, 64'd0);
                        write_register(CFG_MAGIC, '1);
                    end
                endcase
                n_break++;
            end
            if (i % 100 == 0)
                gap_odds = 3 * $urandom_range(2);
            calm = (i >= calm_from);
            if (i == hold_at)
                hold_go = 1'b1;
            if (!calm && $urandom_range(15) < gap_odds)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= stream_q[i];
            do @(posedge clk); while (!s_tready);
        end
        s_tvalid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("delta_patch_applier_top verification clean");
        else
            $display("delta_patch_applier_top verification failed");
        $finish;
    end

    initial
    begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                // long back-pressure so the input queue fills
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else if (!calm && $urandom_range(7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("delta_patch_applier_top verification failed");
        $finish;
    end

endmodule
